/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps
// ils_pkg: shared types and constants for the indexed list store
// no dependencies; used by every module under rtl

package ils_pkg;

  // default sizing of the store
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefDataWidth = 32;

  // fixed field widths on the stream ports
  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned PositionW = 5;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned TotalW    = 5;

  // packed beat widths, rounded up to whole bytes
  localparam int unsigned InBits   = OpcodeW + PositionW + ValueW;
  localparam int unsigned InTdataW = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = ValueW + StatusW + TotalW + 1;
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8;

  // list operations
  typedef enum logic [OpcodeW-1:0] {
    OP_ADD_FRONT    = 3'd0,
    OP_ADD_REAR     = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_REAR  = 3'd3,
    OP_INSERT_AT    = 3'd4,
    OP_REMOVE_AT    = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // one input item
  typedef struct packed {
    logic [OpcodeW-1:0]          opcode;
    logic [PositionW-1:0]        position;
    logic signed [ValueW-1:0]    value;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [ValueW-1:0]    removed_value;
    status_e                     status;
    logic [TotalW-1:0]           entry_total;
    logic                        is_empty;
  } result_t;

endpackage

/* rtl/ils_in_reg.sv */
`timescale 1ns / 1ps
// ils_in_reg: input register stage holding one accepted item
// depends on ils_pkg for the item type

module ils_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ils_pkg::item_t in_item_i,
  input  logic           next_ready_i,
  output logic           fire_o,
  output ils_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  ils_pkg::item_t item_q;

  // item leaves when the result register can take it
  assign fire_o     = valid_q && next_ready_i;
  assign in_ready_o = !valid_q || next_ready_i;
  assign item_o     = item_q;

  // occupancy of the stage
  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* rtl/ils_core.sv */
`timescale 1ns / 1ps
// ils_core: slot array with parallel shift, entry count and status decode
// depends on ils_pkg for item, result, opcode and status types

module ils_core #(
  parameter int unsigned CAPACITY   = ils_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = ils_pkg::DefDataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             apply_i,
  input  ils_pkg::item_t   item_i,
  output ils_pkg::result_t result_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW + 1 > ils_pkg::PositionW + 1) ? CW + 1
                                                                 : ils_pkg::PositionW + 1;

  logic [DATA_WIDTH-1:0] slots_q [CAPACITY];
  logic [DATA_WIDTH-1:0] slots_d [CAPACITY];
  logic [CW-1:0]         cnt_q, cnt_d, cnt_m1;
  logic [EW-1:0]         pos_e, cnt_e, pos_m1;
  logic                  full, empty;
  logic                  do_ins, do_del;
  logic [IW-1:0]         ins_idx, del_idx;
  ils_pkg::status_e      status;
  logic [DATA_WIDTH-1:0] new_val, rd_val;
  logic [63:0]           rd_wide;
  logic [15:0]           cnt_wide;

  // widened operands for the position checks
  assign pos_e  = EW'(item_i.position);
  assign cnt_e  = EW'(cnt_q);
  assign pos_m1 = pos_e - EW'(1);
  assign cnt_m1 = cnt_q - CW'(1);
  assign full   = (cnt_q == CW'(CAPACITY));
  assign empty  = (cnt_q == '0);

  // stored value keeps the low bits, zero filled above the port width
  assign new_val = DATA_WIDTH'({32'b0, item_i.value});

  // operation decode
  always_comb begin
    status  = ils_pkg::ST_OK;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_idx = '0;
    del_idx = '0;
    case (ils_pkg::op_e'(item_i.opcode))
      ils_pkg::OP_ADD_FRONT: begin
        if (full) status = ils_pkg::ST_FULL;
        else      do_ins = 1'b1;
      end
      ils_pkg::OP_ADD_REAR: begin
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = cnt_q[IW-1:0];
        end
      end
      ils_pkg::OP_REMOVE_FRONT: begin
        if (empty) status = ils_pkg::ST_UNDER;
        else       do_del = 1'b1;
      end
      ils_pkg::OP_REMOVE_REAR: begin
        if (empty) begin
          status = ils_pkg::ST_UNDER;
        end else begin
          do_del  = 1'b1;
          del_idx = cnt_m1[IW-1:0];
        end
      end
      ils_pkg::OP_INSERT_AT: begin
        if (pos_e == '0 || pos_e > cnt_e + EW'(1)) begin
          status = ils_pkg::ST_RANGE;
        end else if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = pos_m1[IW-1:0];
        end
      end
      ils_pkg::OP_REMOVE_AT: begin
        if (pos_e == '0 || pos_e > cnt_e) begin
          status = ils_pkg::ST_RANGE;
        end else begin
          do_del  = 1'b1;
          del_idx = pos_m1[IW-1:0];
        end
      end
      default: begin
        status = ils_pkg::ST_OK;
      end
    endcase
  end

  // per-slot next value: insert shifts up, removal closes the gap
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    logic [DATA_WIDTH-1:0] above;
    if (k < CAPACITY - 1) begin : g_mid
      assign above = slots_q[k+1];
    end else begin : g_top
      assign above = slots_q[k];
    end
    if (k > 0) begin : g_up
      always_comb begin
        slots_d[k] = slots_q[k];
        if (do_ins && IW'(k) == ins_idx)     slots_d[k] = new_val;
        else if (do_ins && IW'(k) > ins_idx) slots_d[k] = slots_q[k-1];
        else if (do_del && IW'(k) >= del_idx) slots_d[k] = above;
      end
    end else begin : g_front
      always_comb begin
        slots_d[k] = slots_q[k];
        if (do_ins && ins_idx == '0)      slots_d[k] = new_val;
        else if (do_del && del_idx == '0) slots_d[k] = above;
      end
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      slots_q <= slots_d;
    end
  end

  // entry count
  always_comb begin
    cnt_d = cnt_q;
    if (do_ins)      cnt_d = cnt_q + CW'(1);
    else if (do_del) cnt_d = cnt_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (apply_i) begin
      cnt_q <= cnt_d;
    end
  end

  // result fields
  assign rd_val   = slots_q[del_idx];
  assign rd_wide  = 64'(rd_val);
  assign cnt_wide = 16'(cnt_d);

  always_comb begin
    result_o.removed_value = do_del ? rd_wide[31:0] : '0;
    result_o.status        = status;
    result_o.entry_total   = cnt_wide[ils_pkg::TotalW-1:0];
    result_o.is_empty      = (cnt_d == '0);
  end

endmodule

/* rtl/ils_out_reg.sv */
`timescale 1ns / 1ps
// ils_out_reg: result register in front of the master-side stream
// depends on ils_pkg for the result type

module ils_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ils_pkg::result_t result_i,
  output logic             load_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ils_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  ils_pkg::result_t result_q;

  // a new result may enter when the held beat is empty or leaving
  assign load_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign result_o     = result_q;

  // occupancy of the result register
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

/* rtl/indexed_list_store.sv */
`timescale 1ns / 1ps
// indexed_list_store: ordered list of up to CAPACITY values, one operation per beat
// an accepted input beat is held in the input register, and its result in the result register
// throughput: one item per cycle while the result stream is not stalled, set by the parallel shift of the slot array
// reset: entry count cleared, both stage valids cleared; slot contents are not reset
// depends on ils_pkg, ils_in_reg, ils_core, ils_out_reg

module indexed_list_store #(
  parameter int unsigned CAPACITY   = ils_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = ils_pkg::DefDataWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode [2:0], position [7:3], value [39:8]
  input  logic [ils_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // removed_value [31:0], status [33:32], entry_total [38:34], is_empty [39]
  output logic [ils_pkg::OutTdataW-1:0] m_axis_tdata
);

  ils_pkg::item_t   in_item, cur_item;
  ils_pkg::result_t core_res, out_res;
  logic             fire, load_ready;

  // unpack the input beat
  always_comb begin
    in_item.opcode   = s_axis_tdata[2:0];
    in_item.position = s_axis_tdata[7:3];
    in_item.value    = s_axis_tdata[39:8];
  end

  ils_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .next_ready_i (load_ready),
    .fire_o       (fire),
    .item_o       (cur_item)
  );

  ils_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (fire),
    .item_i   (cur_item),
    .result_o (core_res)
  );

  ils_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .result_i     (core_res),
    .load_ready_o (load_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (out_res)
  );

  // pack the result beat
  assign m_axis_tdata = {out_res.is_empty, out_res.entry_total,
                         out_res.status, out_res.removed_value};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for indexed_list_store, ops streamed through the slave port
// depends on ils_pkg and indexed_list_store; a scoreboard class tracks the list contents

module tb_top;
  import ils_pkg::*;

  // opcodes the block leaves unused
  localparam logic [OpcodeW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpcodeW-1:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned PhaseItems = 430;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MaxPrints  = 50;

  // shadow of the list contents plus the queue of results still owed by the block
  class list_scoreboard;
    logic [ValueW-1:0] slots [DefCapacity];
    int unsigned       count;
    result_t           owed_q [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      count   = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void insert_entry(int unsigned idx, logic [ValueW-1:0] v);
      for (int unsigned k = count; k > idx; k--) slots[k] = slots[k-1];
      slots[idx] = v;
      count++;
    endfunction

    function logic [ValueW-1:0] extract_entry(int unsigned idx);
      logic [ValueW-1:0] v;
      v = slots[idx];
      for (int unsigned k = idx; k + 1 < count; k++) slots[k] = slots[k+1];
      count--;
      return v;
    endfunction

    // apply one accepted op to the shadow list and queue its result
    function void note_input(item_t it);
      result_t r;
      r.removed_value = '0;
      r.status        = ST_OK;
      case (it.opcode)
        OP_ADD_FRONT, OP_ADD_REAR: begin
          if (count >= DefCapacity) r.status = ST_FULL;
          else insert_entry(it.opcode == OP_ADD_FRONT ? 0 : count, it.value);
        end
        OP_REMOVE_FRONT, OP_REMOVE_REAR: begin
          if (count == 0) r.status = ST_UNDER;
          else r.removed_value = extract_entry(it.opcode == OP_REMOVE_FRONT ? 0 : count - 1);
        end
        // range check comes before the full check
        OP_INSERT_AT: begin
          if (it.position < 1 || it.position > count + 1) r.status = ST_RANGE;
          else if (count >= DefCapacity) r.status = ST_FULL;
          else insert_entry(it.position - 1, it.value);
        end
        OP_REMOVE_AT: begin
          if (it.position < 1 || it.position > count) r.status = ST_RANGE;
          else r.removed_value = extract_entry(it.position - 1);
        end
        default: ;
      endcase
      r.entry_total = TotalW'(count);
      r.is_empty    = (count == 0);
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one result beat with the oldest owed result
    task check_result(logic [OutTdataW-1:0] beat);
      result_t           want;
      logic [ValueW-1:0] got_val;
      logic [StatusW-1:0] got_st;
      logic [TotalW-1:0] got_tot;
      logic              got_empty;
      got_val   = beat[ValueW-1:0];
      got_st    = beat[ValueW +: StatusW];
      got_tot   = beat[ValueW+StatusW +: TotalW];
      got_empty = beat[ValueW+StatusW+TotalW];
      if (owed_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got_val !== want.removed_value)
        report_mismatch($sformatf("beat %0d removed_value got %0h want %0h",
                                  checked, got_val, want.removed_value));
      if (got_st !== want.status)
        report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                  checked, got_st, want.status));
      if (got_tot !== want.entry_total)
        report_mismatch($sformatf("beat %0d entry_total got %0d want %0d",
                                  checked, got_tot, want.entry_total));
      if (got_empty !== want.is_empty)
        report_mismatch($sformatf("beat %0d is_empty got %0b want %0b",
                                  checked, got_empty, want.is_empty));
    endtask

    task flag_leftovers();
      while (owed_q.size() != 0) begin
        void'(owed_q.pop_front());
        report_mismatch("result never delivered");
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  list_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    sink_stall_pct = 0;
  int unsigned    hold_reqs = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;
  bit             growing = 1'b1;

  indexed_list_store uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result sink: check accepted beats, then pick tready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_reqs != hold_seen) begin
        hold_seen     <= hold_reqs;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // offer one beat, with random idle cycles ahead of it, until it is taken
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.value, it.position, it.opcode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic send_op(input logic [OpcodeW-1:0] op, input int unsigned pos,
                         input logic [ValueW-1:0] val);
    item_t it;
    it.opcode   = op;
    it.position = PositionW'(pos);
    it.value    = val;
    send_item(it);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed ops that sweep the fill level between empty and full
  task automatic pick_random(output item_t it);
    int unsigned n;
    int unsigned roll;
    bit          add_side;
    n = sb.count;
    if (n >= DefCapacity && $urandom_range(3) == 0) growing = 1'b0;
    if (n == 0 && $urandom_range(3) == 0) growing = 1'b1;
    if ($urandom_range(49) == 0) growing = !growing;
    it.value    = pick_value();
    it.position = PositionW'($urandom_range(31));
    roll = $urandom_range(99);
    if (roll < 3) begin
      it.opcode = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
    end else if (roll < 10) begin
      it.opcode = OpcodeW'($urandom_range(7));
    end else begin
      add_side = ($urandom_range(99) < 75) ? growing : !growing;
      if (add_side) begin
        case ($urandom_range(2))
          0: it.opcode = OP_ADD_FRONT;
          1: it.opcode = OP_ADD_REAR;
          default: begin
            it.opcode = OP_INSERT_AT;
            if ($urandom_range(9) != 0) it.position = PositionW'($urandom_range(n + 1, 1));
          end
        endcase
      end else begin
        case ($urandom_range(2))
          0: it.opcode = OP_REMOVE_FRONT;
          1: it.opcode = OP_REMOVE_REAR;
          default: begin
            it.opcode = OP_REMOVE_AT;
            if ($urandom_range(9) != 0)
              it.position = PositionW'($urandom_range(n > 0 ? n : 1, 1));
          end
        endcase
      end
    end
  endtask

  // main sequence
  initial begin
    item_t it;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-list corner cases
    send_op(OP_REMOVE_FRONT, 0, 32'h1234_5678);
    send_op(OP_REMOVE_REAR, 1, 32'h0);
    send_op(OP_REMOVE_AT, 0, 32'h0);
    send_op(OP_REMOVE_AT, 1, 32'h0);
    send_op(OP_INSERT_AT, 0, 32'h5555_aaaa);
    send_op(OP_INSERT_AT, 2, 32'haaaa_5555);
    send_op(OP_INSERT_AT, 1, 32'h8000_0000);
    send_op(OP_SPARE_6, 31, 32'hffff_ffff);
    send_op(OP_SPARE_7, 5, 32'h0);

    // fill to capacity through every add path
    for (int k = 0; k < 15; k++) begin
      case (k % 3)
        0: send_op(OP_ADD_FRONT, 0, pick_value());
        1: send_op(OP_ADD_REAR, 31, pick_value());
        default: send_op(OP_INSERT_AT, sb.count / 2 + 1, pick_value());
      endcase
    end

    // full-list corner cases
    send_op(OP_ADD_REAR, 0, 32'h7fff_ffff);
    send_op(OP_INSERT_AT, DefCapacity + 1, 32'h1);
    send_op(OP_INSERT_AT, 31, 32'h2);
    send_op(OP_REMOVE_AT, DefCapacity + 1, 32'h0);
    send_op(OP_REMOVE_AT, DefCapacity, 32'h0);

    // long sink hold-off while the source keeps pushing
    hold_reqs <= hold_reqs + 1;
    for (int k = 0; k < 40; k++) begin
      pick_random(it);
      send_item(it);
    end

    // random traffic under each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin send_idle_pct = 81; sink_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct <= 81; end
        default: begin send_idle_pct = 31; sink_stall_pct <= 31; end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        pick_random(it);
        send_item(it);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ils_pkg.sv
rtl/ils_in_reg.sv
rtl/ils_core.sv
rtl/ils_out_reg.sv
rtl/indexed_list_store.sv
tb/tb_top.sv
